// ===== sv/ixl_pkg.sv =====
// ----------------------------------------------------------------------------
// ixl_pkg: shared types and constants of the indexed insert/delete list
// Array geometry, operation and status codes, controller states and the
// control bundle that the controller sends to every storage cell.
// ----------------------------------------------------------------------------
package ixl_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int GRP        = 8;
  localparam int NGRP       = (DEPTH + GRP - 1) / GRP;

  // Field widths of the channels
  localparam int OP_W   = 2;
  localparam int POS_W  = 6;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int RD_W   = 32;
  localparam int OCNT_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FIN
  } state_t;

  // Control bundle broadcast to the cell row
  typedef struct packed {
    logic                  ins;
    logic                  del;
    logic [IDX_W-1:0]      pos;
    logic [DATA_WIDTH-1:0] val;
  } cell_ctl_t;

endpackage

// ===== sv/ixl_if.sv =====
// ----------------------------------------------------------------------------
// ixl_if: valid/ready channels of the indexed insert/delete list
// One interface for the operation beats and one for the result beats.
// ----------------------------------------------------------------------------
interface ixl_in_if;
  logic                       valid;
  logic                       ready;
  logic [ixl_pkg::OP_W-1:0]   op;
  logic [ixl_pkg::POS_W-1:0]  position;
  logic [ixl_pkg::VAL_W-1:0]  value;

  modport source (output valid, output op, output position, output value, input ready);
  modport sink   (input valid, input op, input position, input value, output ready);
endinterface

interface ixl_out_if;
  logic                        valid;
  logic                        ready;
  logic [ixl_pkg::STAT_W-1:0]  status;
  logic [ixl_pkg::RD_W-1:0]    read_value;
  logic [ixl_pkg::OCNT_W-1:0]  count;

  modport source (output valid, output status, output read_value, output count, input ready);
  modport sink   (input valid, input status, input read_value, input count, output ready);
endinterface

// ===== sv/ixl_cell.sv =====
// ----------------------------------------------------------------------------
// ixl_cell: one slot of the ordered array
// Holds one entry; on insert takes the lower neighbor's entry or the new
// value, on remove takes the upper neighbor's entry. Drives its entry onto
// the read lines when its slot is the addressed one.
// ----------------------------------------------------------------------------
module ixl_cell (
  input  logic                               clk,
  input  ixl_pkg::cell_ctl_t                 ctl,
  input  logic [ixl_pkg::IDX_W-1:0]          idx,
  input  logic [ixl_pkg::DATA_WIDTH-1:0]     below_data,
  input  logic [ixl_pkg::DATA_WIDTH-1:0]     above_data,
  output logic [ixl_pkg::DATA_WIDTH-1:0]     data,
  output logic [ixl_pkg::DATA_WIDTH-1:0]     rd_data
);

  logic [ixl_pkg::DATA_WIDTH-1:0] data_r;
  logic [ixl_pkg::DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.ins) begin
      if (idx > ctl.pos) begin
        data_nxt = below_data;
      end else if (idx == ctl.pos) begin
        data_nxt = ctl.val;
      end
    end else if (ctl.del) begin
      if (idx >= ctl.pos) begin
        data_nxt = above_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data    = data_r;
  assign rd_data = (idx == ctl.pos) ? data_r : '0;

endmodule

// ===== sv/indexed_insert_delete_list_top.sv =====
// ----------------------------------------------------------------------------
// indexed_insert_delete_list_top: fixed-capacity ordered array
// Insert, remove and read by position over a row of shifting cells.
// ----------------------------------------------------------------------------
// The array holds up to DEPTH entries in a row of cells, slot 0 at the
// bottom. A beat is captured at the edge that accepts it, and its result
// passes the execute and finish states into the result register. In the
// execute state every cell compares its slot with the position and shifts in
// parallel (and the read lines are OR-reduced into eight group registers). In
// the finish state the groups combine into the result register. A new beat is
// accepted as soon as the controller is back in idle, even while the previous
// result still waits on the output; the result stage then holds until the
// output frees up. Each beat passes the idle state that takes it, the cell
// update and the second level of the read tree before the next is taken.
// Every beat returns exactly one result: status (ok, out of range, full),
// the read value (zero unless a read succeeded) and the entry count after
// the operation. An insert into a full array reports full and changes
// nothing; reserved op codes report out of range.
// ----------------------------------------------------------------------------
module indexed_insert_delete_list_top (
  input  logic      clk,
  input  logic      rst_n,
  ixl_in_if.sink    in_bus,
  ixl_out_if.source out_bus
);

  // Captured operation
  logic [ixl_pkg::OP_W-1:0]       op_r;
  logic [ixl_pkg::IDX_W-1:0]      pos_r;
  logic [ixl_pkg::DATA_WIDTH-1:0] val_r;

  // Controller state and entry count
  ixl_pkg::state_t                state_r, state_nxt;
  logic [ixl_pkg::CNT_W-1:0]      count_r, count_nxt;

  // Outcome of the execute cycle, held for the finish cycle
  logic [ixl_pkg::STAT_W-1:0]     stat_r, stat_nxt;
  logic                           rd_ok_r, rd_ok_nxt;

  // Read tree
  logic [ixl_pkg::DATA_WIDTH-1:0] grp_r   [ixl_pkg::NGRP];
  logic [ixl_pkg::DATA_WIDTH-1:0] grp_nxt [ixl_pkg::NGRP];
  logic [ixl_pkg::DATA_WIDTH-1:0] rd_sum;

  // Output register
  logic                           out_valid_r, out_valid_nxt;
  logic [ixl_pkg::STAT_W-1:0]     out_status_r;
  logic [ixl_pkg::RD_W-1:0]       out_rdata_r;
  logic [ixl_pkg::OCNT_W-1:0]     out_count_r;
  logic                           out_load;

  // Cell row
  ixl_pkg::cell_ctl_t             ctl;
  logic                           ins_ok, del_ok;
  logic [ixl_pkg::DATA_WIDTH-1:0] cell_q  [ixl_pkg::DEPTH];
  logic [ixl_pkg::DATA_WIDTH-1:0] cell_rd [ixl_pkg::DEPTH];

  logic in_fire;

  assign in_bus.ready = (state_r == ixl_pkg::ST_IDLE);
  assign in_fire      = in_bus.valid && in_bus.ready;

  // Capture the beat; payload needs no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_bus.op;
      pos_r <= in_bus.position;
      val_r <= in_bus.value;
    end
  end

  // Decide the operation outcome during the execute cycle
  always_comb begin
    ins_ok    = 1'b0;
    del_ok    = 1'b0;
    stat_nxt  = stat_r;
    rd_ok_nxt = rd_ok_r;
    count_nxt = count_r;
    if (state_r == ixl_pkg::ST_EXEC) begin
      stat_nxt  = ixl_pkg::STAT_RANGE;
      rd_ok_nxt = 1'b0;
      unique case (ixl_pkg::op_t'(op_r))
        ixl_pkg::OP_INSERT: begin
          if (count_r == ixl_pkg::CNT_W'(ixl_pkg::DEPTH)) begin
            stat_nxt = ixl_pkg::STAT_FULL;
          end else if (ixl_pkg::CNT_W'(pos_r) <= count_r) begin
            ins_ok    = 1'b1;
            stat_nxt  = ixl_pkg::STAT_OK;
            count_nxt = count_r + 1'b1;
          end
        end
        ixl_pkg::OP_REMOVE: begin
          if (ixl_pkg::CNT_W'(pos_r) < count_r) begin
            del_ok    = 1'b1;
            stat_nxt  = ixl_pkg::STAT_OK;
            count_nxt = count_r - 1'b1;
          end
        end
        ixl_pkg::OP_READ: begin
          if (ixl_pkg::CNT_W'(pos_r) < count_r) begin
            rd_ok_nxt = 1'b1;
            stat_nxt  = ixl_pkg::STAT_OK;
          end
        end
        default: begin
          stat_nxt = ixl_pkg::STAT_RANGE;
        end
      endcase
    end
  end

  assign ctl.ins = ins_ok;
  assign ctl.del = del_ok;
  assign ctl.pos = pos_r;
  assign ctl.val = val_r;

  // Row of cells: each takes from its lower neighbor on insert and from its
  // upper neighbor on remove; the ends see zero.
  for (genvar i = 0; i < ixl_pkg::DEPTH; i++) begin : g_cell
    logic [ixl_pkg::DATA_WIDTH-1:0] below_d;
    logic [ixl_pkg::DATA_WIDTH-1:0] above_d;

    if (i == 0) begin : g_bot
      assign below_d = '0;
    end else begin : g_mid_lo
      assign below_d = cell_q[i-1];
    end

    if (i == ixl_pkg::DEPTH - 1) begin : g_top
      assign above_d = '0;
    end else begin : g_mid_hi
      assign above_d = cell_q[i+1];
    end

    ixl_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .idx        (ixl_pkg::IDX_W'(i)),
      .below_data (below_d),
      .above_data (above_d),
      .data       (cell_q[i]),
      .rd_data    (cell_rd[i])
    );
  end

  // First level of the read tree: OR each group of cells
  always_comb begin
    for (int g = 0; g < ixl_pkg::NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < ixl_pkg::GRP; k++) begin
        if (g * ixl_pkg::GRP + k < ixl_pkg::DEPTH) begin
          grp_nxt[g] = grp_nxt[g] | cell_rd[g * ixl_pkg::GRP + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ixl_pkg::ST_EXEC) begin
      for (int g = 0; g < ixl_pkg::NGRP; g++) begin
        grp_r[g] <= grp_nxt[g];
      end
    end
  end

  // Second level: combine the groups
  always_comb begin
    rd_sum = '0;
    for (int g = 0; g < ixl_pkg::NGRP; g++) begin
      rd_sum = rd_sum | grp_r[g];
    end
  end

  // Controller: advance through capture, execute and finish; hold in finish
  // while the output register is still occupied.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_load      = 1'b0;
    if (out_bus.valid && out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ixl_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ixl_pkg::ST_EXEC;
        end
      end
      ixl_pkg::ST_EXEC: begin
        state_nxt = ixl_pkg::ST_FIN;
      end
      ixl_pkg::ST_FIN: begin
        if (!out_valid_r || out_bus.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ixl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ixl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ixl_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      stat_r      <= ixl_pkg::STAT_OK;
      rd_ok_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      stat_r      <= stat_nxt;
      rd_ok_r     <= rd_ok_nxt;
    end
  end

  // Result payload; zero the read value unless a read succeeded
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= stat_r;
      out_rdata_r  <= rd_ok_r ? ixl_pkg::RD_W'(rd_sum) : '0;
      out_count_r  <= ixl_pkg::OCNT_W'(count_r);
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.status     = out_status_r;
  assign out_bus.read_value = out_rdata_r;
  assign out_bus.count      = out_count_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ixl_pkg::CNT_W'(ixl_pkg::DEPTH))
    else $error("entry count above capacity");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    ins_ok |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not bump the count");

  a_del_count: assert property (@(posedge clk) disable iff (!rst_n)
    del_ok |=> count_r == $past(count_r) - 1'b1)
    else $error("remove did not drop the count");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && stat_r == ixl_pkg::STAT_FULL |-> count_r == ixl_pkg::CNT_W'(ixl_pkg::DEPTH))
    else $error("full reported below capacity");
`endif

endmodule
